// ===== src/ttm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttm_pkg
// shared types and codes of the timeout table manager
// ----------------------------------------------------------------------------
package ttm_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_ACK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_CREATED      = 3'd0,
    K_REMOVED      = 3'd1,
    K_NOT_FOUND    = 3'd2,
    K_TABLE_FULL   = 3'd3,
    K_FIRED        = 3'd4,
    K_TICK_NONE    = 3'd5,
    K_KEPT         = 3'd6,
    K_DONE_REMOVED = 3'd7
  } kind_t;

  localparam int MaxResults = 16;

  // one accepted item as it waits for the back end
  typedef struct packed {
    op_t         op;
    logic [31:0] timer_id;
    logic [31:0] duration_ms;
    logic        repeat_req;
  } cmd_t;

  // one result as it leaves the back end
  typedef struct packed {
    kind_t       kind;
    logic [31:0] result_id;
    logic        any_active;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

endpackage

// ===== src/ttm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttm_front
// input stage and two-entry command queue in front of the table engine
// ----------------------------------------------------------------------------
module ttm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ttm_pkg::cmd_t  in_cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output ttm_pkg::cmd_t  cmd
);

  ttm_pkg::cmd_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/ttm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttm_back
// timer table and slot scanner: one slot per cycle unless a result waits
// on a full output; results through a one-entry output register
// ----------------------------------------------------------------------------
module ttm_back #(
  parameter int MAX_TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ttm_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output ttm_pkg::res_t res
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int RW = $clog2(ttm_pkg::MaxResults + 1);

  logic [MAX_TIMERS-1:0] slot_valid;
  logic [31:0]           slot_id       [MAX_TIMERS];
  logic [31:0]           slot_duration [MAX_TIMERS];
  logic [31:0]           slot_elapsed  [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] slot_repeat;
  logic [MAX_TIMERS-1:0] slot_done;
  logic [31:0]           next_id;

  ttm_pkg::state_t state, state_next;
  ttm_pkg::cmd_t   cur;
  logic [IW-1:0]   idx;
  logic            found;
  logic [IW-1:0]   hit;
  logic [RW-1:0]   nres;
  // pending result waiting for the lookahead of any_active / last
  logic            pend;
  ttm_pkg::kind_t  pend_kind;
  logic [31:0]     pend_id;

  logic          scan_last;
  logic [31:0]   el_inc;
  logic          fire;
  logic          emit;
  logic          res_load;
  logic          out_free;
  logic          match;

  assign scan_last = (idx == IW'(MAX_TIMERS - 1));
  assign el_inc    = (slot_elapsed[idx] == 32'hFFFF_FFFF) ? slot_elapsed[idx]
                                                          : slot_elapsed[idx] + 32'd1;
  assign fire      = slot_valid[idx] && !slot_done[idx] && (el_inc >= slot_duration[idx]);
  assign match     = slot_valid[idx] && (slot_id[idx] == cur.timer_id);
  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ttm_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ttm_pkg::ST_IDLE: if (cmd_valid) state_next = ttm_pkg::ST_SCAN;
      ttm_pkg::ST_SCAN: begin
        // a fire that is still reported pushes the earlier pending result out
        emit = (cur.op == ttm_pkg::OP_TICK) && fire && pend
               && (nres < RW'(ttm_pkg::MaxResults));
        res_load = emit && out_free;
        if (emit && !out_free) state_next = ttm_pkg::ST_SCAN;
        else if (scan_last) state_next = ttm_pkg::ST_EMIT;
      end
      ttm_pkg::ST_EMIT: begin
        res_load = out_free;
        if (out_free) state_next = ttm_pkg::ST_IDLE;
      end
      default: state_next = ttm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttm_pkg::ST_IDLE;
      slot_valid <= '0;
      next_id    <= 32'd1;
      res_valid  <= 1'b0;
      idx        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      nres       <= '0;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        ttm_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            idx   <= '0;
            found <= 1'b0;
            pend  <= 1'b0;
            nres  <= '0;
            hit   <= '0;
          end
        end
        ttm_pkg::ST_SCAN: begin
          if (!(emit && !out_free)) begin
            case (cur.op)
              ttm_pkg::OP_CREATE: begin
                if (!found && !slot_valid[idx]) begin
                  found <= 1'b1;
                  hit   <= idx;
                end
              end
              ttm_pkg::OP_TICK: begin
                if (slot_valid[idx] && !slot_done[idx]) begin
                  slot_elapsed[idx] <= (fire && slot_repeat[idx]) ? 32'd0 : el_inc;
                  if (fire) begin
                    if (!slot_repeat[idx]) slot_done[idx] <= 1'b1;
                    if (nres < RW'(ttm_pkg::MaxResults)) begin
                      nres      <= nres + RW'(1);
                      pend      <= 1'b1;
                      pend_kind <= ttm_pkg::K_FIRED;
                      pend_id   <= slot_id[idx];
                    end
                  end
                end
              end
              default: begin
                if (!found && match) begin
                  found <= 1'b1;
                  hit   <= idx;
                end
              end
            endcase
            if (emit) begin
              res.kind       <= pend_kind;
              res.result_id  <= pend_id;
              res.any_active <= |slot_valid;
              res.last       <= 1'b0;
            end
            if (!scan_last) idx <= idx + IW'(1);
          end
        end
        ttm_pkg::ST_EMIT: begin
          if (out_free) begin
            res.last  <= 1'b1;
            case (cur.op)
              ttm_pkg::OP_CREATE: begin
                if (found) begin
                  slot_valid[hit]    <= 1'b1;
                  slot_id[hit]       <= next_id;
                  slot_duration[hit] <= cur.duration_ms;
                  slot_elapsed[hit]  <= 32'd0;
                  slot_repeat[hit]   <= cur.repeat_req;
                  slot_done[hit]     <= 1'b0;
                  next_id <= (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
                  res.kind       <= ttm_pkg::K_CREATED;
                  res.result_id  <= next_id;
                  res.any_active <= 1'b1;
                end else begin
                  res.kind       <= ttm_pkg::K_TABLE_FULL;
                  res.result_id  <= 32'd0;
                  res.any_active <= |slot_valid;
                end
              end
              ttm_pkg::OP_TICK: begin
                res.kind       <= pend ? pend_kind : ttm_pkg::K_TICK_NONE;
                res.result_id  <= pend ? pend_id : 32'd0;
                res.any_active <= |slot_valid;
              end
              default: begin
                if (!found) begin
                  res.kind       <= ttm_pkg::K_NOT_FOUND;
                  res.result_id  <= 32'd0;
                  res.any_active <= |slot_valid;
                end else if (cur.op == ttm_pkg::OP_REMOVE || slot_done[hit]) begin
                  slot_valid[hit] <= 1'b0;
                  res.kind <= (cur.op == ttm_pkg::OP_REMOVE) ? ttm_pkg::K_REMOVED
                                                              : ttm_pkg::K_DONE_REMOVED;
                  res.result_id  <= cur.timer_id;
                  res.any_active <= |(slot_valid & ~(MAX_TIMERS'(1) << hit));
                end else begin
                  res.kind       <= ttm_pkg::K_KEPT;
                  res.result_id  <= cur.timer_id;
                  res.any_active <= |slot_valid;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/timeout_table_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_table_manager_core
// table of MAX_TIMERS millisecond timers driven by create, remove, tick and
// execute-acknowledge commands
// ----------------------------------------------------------------------------
// Every command walks all MAX_TIMERS slots in the table engine, one per
// cycle while no waiting result holds it up downstream, between the IDLE
// state that picks it up and the EMIT state for its final result. A
// two-entry command queue takes new items while the engine works. A tick
// returns one fired result per expiring timer in slot order, up to
// MaxResults (or one tick_none); any_active is the table occupancy
// after the step and last marks the final result of a command.
module timeout_table_manager_core #(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] timer_id, [63:32] duration_ms, [64] repeat_req, zero fill
  input  logic [71:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_id, [32] any_active, zero fill
  output logic [39:0] m_axis_tdata,
  // [2:0] kind
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  ttm_pkg::cmd_t in_cmd;
  ttm_pkg::cmd_t cmd;
  ttm_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_ready;

  assign in_cmd.op          = ttm_pkg::op_t'(s_axis_tuser);
  assign in_cmd.timer_id    = s_axis_tdata[31:0];
  assign in_cmd.duration_ms = s_axis_tdata[63:32];
  assign in_cmd.repeat_req  = s_axis_tdata[64];

  ttm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ttm_back #(.MAX_TIMERS(MAX_TIMERS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {7'd0, res.any_active, res.result_id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
